>>> src/column_occlusion_clipper_top_defines.svh
// Assertion macros for the column occlusion clipper.
`ifndef COLUMN_OCCLUSION_CLIPPER_TOP_DEFINES_SVH
`define COLUMN_OCCLUSION_CLIPPER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define CCL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("column occlusion clipper check failed");
// Next-cycle implication, checked outside reset.
`define CCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("column occlusion clipper check failed");
`else
`define CCL_ASSERT_NOW(label, ante, cons)
`define CCL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/ccl_pkg.sv
// Shared types and constants of the column occlusion clipper.
package ccl_pkg;

  localparam int COL_W    = 16;
  localparam int DEPTH_W  = 16;
  localparam int DIV_W    = 32;
  localparam int PIECE_CW = 6;
  localparam logic [PIECE_CW-1:0] RESULT_LIMIT = 6'd33;

  localparam logic [1:0] OP_CLIP  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] KIND_VISIBLE = 2'd0;
  localparam logic [1:0] KIND_HIDDEN  = 2'd1;
  localparam logic [1:0] KIND_ANSWER  = 2'd2;
  localparam logic [1:0] KIND_CLEARED = 2'd3;

  // Insertion broadcast to every cell of the occluder chain.
  typedef struct packed {
    logic                    en;
    logic signed [COL_W-1:0] left;
    logic signed [COL_W-1:0] right;
  } ins_t;

endpackage

>>> src/ccl_cell.sv
// One cell of the sorted occluder chain.
module ccl_cell (
  input  logic                           clk_i,
  input  ccl_pkg::ins_t                  ins_i,
  input  logic                           valid_i,
  input  logic                           prev_keep_i,
  input  logic signed [ccl_pkg::COL_W-1:0] prev_left_i,
  input  logic signed [ccl_pkg::COL_W-1:0] prev_right_i,
  output logic                           keep_o,
  output logic signed [ccl_pkg::COL_W-1:0] left_o,
  output logic signed [ccl_pkg::COL_W-1:0] right_o
);

  logic signed [ccl_pkg::COL_W-1:0] left_q;
  logic signed [ccl_pkg::COL_W-1:0] right_q;

  // A stored range stays put when it sorts at or before the new one.
  assign keep_o  = valid_i && (left_q <= ins_i.left);
  assign left_o  = left_q;
  assign right_o = right_q;

  // Otherwise it takes the new range or the range of its left neighbor.
  always_ff @(posedge clk_i) begin
    if (ins_i.en && !keep_o) begin
      left_q  <= prev_keep_i ? ins_i.left  : prev_left_i;
      right_q <= prev_keep_i ? ins_i.right : prev_right_i;
    end
  end

endmodule

>>> src/ccl_div.sv
// Restoring divider, one quotient bit per cycle.
module ccl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccl_pkg::DIV_W-1:0]     dividend_i,
  input  logic [ccl_pkg::DEPTH_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [ccl_pkg::DIV_W-1:0]     quotient_o
);

  localparam int CNT_W = $clog2(ccl_pkg::DIV_W + 1);

  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [ccl_pkg::DEPTH_W:0]      rem_q, rem_d;
  logic [ccl_pkg::DIV_W-1:0]      quo_q, quo_d;
  logic [ccl_pkg::DEPTH_W-1:0]    dvs_q, dvs_d;
  logic [ccl_pkg::DEPTH_W:0]      shifted;

  assign shifted    = {rem_q[ccl_pkg::DEPTH_W-1:0], quo_q[ccl_pkg::DIV_W-1]};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Shift in one dividend bit and subtract when the divisor fits.
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CNT_W'(ccl_pkg::DIV_W);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[ccl_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[ccl_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

>>> src/column_occlusion_clipper_top.sv
// Top level of the column occlusion clipper.
// Requests enter on the s_axis channel: tuser carries the opcode (clip, query,
// clear) and tdata the span and its end distances. Results leave on m_axis:
// tuser carries the result kind, tlast marks the final result of a request.
// One request is worked on at a time; s_axis_tready is high only when idle.
// A clear goes straight to the done state. A query walks the occluder chain at
// one entry per cycle. A clip walks the chain the same way, and every visible
// piece adds two distance interpolations, each a multiply and a restoring
// division in the shared divider (skipped for a one-column span), then a store
// step that inserts the piece into the chain if it is opaque and the table has room.
// Each visible piece is held back until the next piece or the end of the walk
// is known, so that tlast can be set on the true final result.
// Reset empties the occluder table and drops any result in flight. When the
// receiver stalls, the result stays in the output register and the walk
// waits for the register to be free before it hands on the next result.
`include "column_occlusion_clipper_top_defines.svh"
module column_occlusion_clipper_top #(
  parameter int MAX_OCCLUDERS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // span_left, span_right, depth_left, depth_right, is_solid, zero fill
  input  logic [71:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // piece_left, piece_right, piece_depth_left, piece_depth_right,
  // uncovered, dropped, zero fill
  output logic [71:0] m_axis_tdata,
  // kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int CW = $clog2(MAX_OCCLUDERS + 1);
  localparam int PW = ccl_pkg::PIECE_CW;
  localparam int XW = ccl_pkg::COL_W;
  localparam int DW = ccl_pkg::DEPTH_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic signed [XW-1:0]    xl_q, xl_d, xr_q, xr_d;
  logic [DW-1:0]           dl_q, dl_d, dr_q, dr_d;
  logic                    solid_q, solid_d;
  logic signed [XW:0]      cur_q, cur_d;
  logic [CW-1:0]           idx_q, idx_d, cnt_q, cnt_d;
  logic [PW-1:0]           np_q, np_d;
  logic                    unc_q, unc_d;
  logic                    side_q, side_d;
  logic signed [XW-1:0]    npl_q, npl_d, npr_q, npr_d;
  logic [DW-1:0]           ndl_q, ndl_d, ndr_q, ndr_d;
  logic                    neg_q, neg_d;
  logic                    pend_q, pend_d;
  logic signed [XW-1:0]    pl_q, pl_d, pr_q, pr_d;
  logic [DW-1:0]           pdl_q, pdl_d, pdr_q, pdr_d;
  logic                    pdrop_q, pdrop_d;

  logic                    ov_q, ov_d;
  logic [1:0]              okind_q, okind_d;
  logic signed [XW-1:0]    opl_q, opl_d, opr_q, opr_d;
  logic [DW-1:0]           odl_q, odl_d, odr_q, odr_d;
  logic                    ounc_q, ounc_d, odrop_q, odrop_d, olast_q, olast_d;

  logic                    slot_free;
  logic                    in_acc;
  ccl_pkg::ins_t           ins;

  logic signed [XW-1:0]    cl [MAX_OCCLUDERS];
  logic signed [XW-1:0]    cr [MAX_OCCLUDERS];
  logic                    keep [MAX_OCCLUDERS];
  logic signed [XW-1:0]    e_l, e_r;
  logic signed [XW:0]      xr17, el17, er1, el_m1;
  logic                    active;

  logic signed [XW:0]      span, diff, off;
  logic signed [2*XW+1:0]  prod;
  logic [2*XW+1:0]         mag;
  logic                    div_start, div_done;
  logic [ccl_pkg::DIV_W-1:0] quo;
  logic [DW-1:0]           qdepth;

  assign slot_free     = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Occluder chain: ranges kept sorted by left column.
  for (genvar g = 0; g < MAX_OCCLUDERS; g++) begin : g_cell
    logic                 pk;
    logic signed [XW-1:0] pl, pr;
    if (g == 0) begin : g_first
      assign pk = 1'b1;
      assign pl = '0;
      assign pr = '0;
    end else begin : g_rest
      assign pk = keep[g-1];
      assign pl = cl[g-1];
      assign pr = cr[g-1];
    end
    ccl_cell u_cell (
      .clk_i        (clk_i),
      .ins_i        (ins),
      .valid_i      (CW'(g) < cnt_q),
      .prev_keep_i  (pk),
      .prev_left_i  (pl),
      .prev_right_i (pr),
      .keep_o       (keep[g]),
      .left_o       (cl[g]),
      .right_o      (cr[g])
    );
  end

  // Entry at the walk position.
  always_comb begin
    e_l = '0;
    e_r = '0;
    for (int k = 0; k < MAX_OCCLUDERS; k++) begin
      if (idx_q == CW'(k)) begin
        e_l = cl[k];
        e_r = cr[k];
      end
    end
  end

  assign xr17   = {xr_q[XW-1], xr_q};
  assign el17   = {e_l[XW-1], e_l};
  assign er1    = {e_r[XW-1], e_r} + 17'sd1;
  assign el_m1  = el17 - 17'sd1;
  assign active = (idx_q < cnt_q) && (cur_q <= xr17);

  // Interpolation: product of distance step and column offset.
  assign span = {xr_q[XW-1], xr_q} - {xl_q[XW-1], xl_q};
  assign diff = $signed({1'b0, dr_q}) - $signed({1'b0, dl_q});
  assign off  = side_q ? ({npr_q[XW-1], npr_q} - {xl_q[XW-1], xl_q})
                       : ({npl_q[XW-1], npl_q} - {xl_q[XW-1], xl_q});
  assign prod = diff * off;
  assign mag  = prod[2*XW+1] ? (-prod) : prod;
  assign div_start = (state_q == S_MUL) && (span != '0);
  assign qdepth    = neg_q ? (dl_q - quo[DW-1:0]) : (dl_q + quo[DW-1:0]);

  ccl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag[ccl_pkg::DIV_W-1:0]),
    .divisor_i  (span[DW-1:0]),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Insertion of an opaque piece when the table has room.
  always_comb begin
    ins.en    = (state_q == S_STORE) && solid_q && (cnt_q < CW'(MAX_OCCLUDERS));
    ins.left  = npl_q;
    ins.right = npr_q;
  end

  // Request sequencer.
  always_comb begin
    state_d = state_q;
    op_d = op_q; xl_d = xl_q; xr_d = xr_q; dl_d = dl_q; dr_d = dr_q;
    solid_d = solid_q; cur_d = cur_q; idx_d = idx_q; cnt_d = cnt_q;
    np_d = np_q; unc_d = unc_q; side_d = side_q;
    npl_d = npl_q; npr_d = npr_q; ndl_d = ndl_q; ndr_d = ndr_q; neg_d = neg_q;
    pend_d = pend_q; pl_d = pl_q; pr_d = pr_q; pdl_d = pdl_q; pdr_d = pdr_q;
    pdrop_d = pdrop_q;
    ov_d = ov_q && !m_axis_tready;
    okind_d = okind_q; opl_d = opl_q; opr_d = opr_q; odl_d = odl_q; odr_d = odr_q;
    ounc_d = ounc_q; odrop_d = odrop_q; olast_d = olast_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = s_axis_tuser;
          xl_d    = s_axis_tdata[15:0];
          xr_d    = s_axis_tdata[31:16];
          dl_d    = s_axis_tdata[47:32];
          dr_d    = s_axis_tdata[63:48];
          solid_d = s_axis_tdata[64];
          cur_d   = {s_axis_tdata[15], s_axis_tdata[15:0]};
          idx_d   = '0;
          np_d    = '0;
          unc_d   = 1'b0;
          pend_d  = 1'b0;
          case (s_axis_tuser)
            ccl_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_DONE;
            end
            ccl_pkg::OP_CLIP, ccl_pkg::OP_QUERY: state_d = S_WALK;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (!active) begin
          if (op_q == ccl_pkg::OP_QUERY) begin
            unc_d   = (cur_q <= xr17);
            state_d = S_DONE;
          end else if ((cur_q <= xr17) && (np_q < ccl_pkg::RESULT_LIMIT)) begin
            npl_d   = cur_q[XW-1:0];
            npr_d   = xr_q;
            np_d    = np_q + 1'b1;
            cur_d   = xr17 + 17'sd1;
            state_d = S_FLUSH;
          end else begin
            state_d = S_DONE;
          end
        end else if (op_q == ccl_pkg::OP_QUERY) begin
          if (cur_q < el17) begin
            unc_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            if (er1 > cur_q) cur_d = er1;
            idx_d = idx_q + 1'b1;
          end
        end else if (xr17 < el17) begin
          // Segment ends before this occluder.
          if (np_q < ccl_pkg::RESULT_LIMIT) begin
            npl_d   = cur_q[XW-1:0];
            npr_d   = xr_q;
            np_d    = np_q + 1'b1;
            state_d = S_FLUSH;
          end
          cur_d = xr17 + 17'sd1;
        end else if (cur_q < el17) begin
          // Gap in front of this occluder.
          if (np_q < ccl_pkg::RESULT_LIMIT) begin
            npl_d   = cur_q[XW-1:0];
            npr_d   = el_m1[XW-1:0];
            np_d    = np_q + 1'b1;
            state_d = S_FLUSH;
          end
          cur_d = er1;
          idx_d = idx_q + 1'b1;
        end else begin
          if (er1 > cur_q) cur_d = er1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_FLUSH: begin
        // Hand on the held piece now that another one follows.
        if (!pend_q || slot_free) begin
          if (pend_q) begin
            ov_d = 1'b1; okind_d = ccl_pkg::KIND_VISIBLE;
            opl_d = pl_q; opr_d = pr_q; odl_d = pdl_q; odr_d = pdr_q;
            ounc_d = 1'b0; odrop_d = pdrop_q; olast_d = 1'b0;
          end
          pend_d  = 1'b0;
          side_d  = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (span == '0) begin
          ndl_d   = dl_q;
          ndr_d   = dl_q;
          state_d = S_STORE;
        end else begin
          neg_d   = prod[2*XW+1];
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (side_q) begin
            ndr_d   = qdepth;
            state_d = S_STORE;
          end else begin
            ndl_d   = qdepth;
            side_d  = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_STORE: begin
        pend_d  = 1'b1;
        pl_d = npl_q; pr_d = npr_q; pdl_d = ndl_q; pdr_d = ndr_q;
        pdrop_d = solid_q && !ins.en;
        if (ins.en) cnt_d = cnt_q + 1'b1;
        state_d = S_WALK;
      end
      S_DONE: begin
        if (slot_free) begin
          ov_d = 1'b1;
          opl_d = '0; opr_d = '0; odl_d = '0; odr_d = '0;
          ounc_d = 1'b0; odrop_d = 1'b0; olast_d = 1'b1;
          case (op_q)
            ccl_pkg::OP_CLEAR: okind_d = ccl_pkg::KIND_CLEARED;
            ccl_pkg::OP_QUERY: begin
              okind_d = ccl_pkg::KIND_ANSWER;
              ounc_d  = unc_q;
            end
            default: begin
              if (pend_q) begin
                okind_d = ccl_pkg::KIND_VISIBLE;
                opl_d = pl_q; opr_d = pr_q; odl_d = pdl_q; odr_d = pdr_q;
                odrop_d = pdrop_q;
              end else begin
                okind_d = ccl_pkg::KIND_HIDDEN;
              end
            end
          endcase
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; xl_q <= xl_d; xr_q <= xr_d; dl_q <= dl_d; dr_q <= dr_d;
    solid_q <= solid_d; cur_q <= cur_d; idx_q <= idx_d; np_q <= np_d;
    unc_q <= unc_d; side_q <= side_d; npl_q <= npl_d; npr_q <= npr_d;
    ndl_q <= ndl_d; ndr_q <= ndr_d; neg_q <= neg_d;
    pl_q <= pl_d; pr_q <= pr_d; pdl_q <= pdl_d; pdr_q <= pdr_d; pdrop_q <= pdrop_d;
    okind_q <= okind_d; opl_q <= opl_d; opr_q <= opr_d; odl_q <= odl_d;
    odr_q <= odr_d; ounc_q <= ounc_d; odrop_q <= odrop_d; olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {6'd0, odrop_q, ounc_q, odr_q, odl_q, opr_q, opl_q};

  // Checks on the occluder table, the divider and the emitted pieces.
  `CCL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_OCCLUDERS))
  `CCL_ASSERT_NOW(a_ins_room, ins.en, cnt_q < CW'(MAX_OCCLUDERS))
  `CCL_ASSERT_NOW(a_div_state, div_done, state_q == S_DIV)
  `CCL_ASSERT_NEXT(a_piece_order, state_q == S_STORE, $signed(pl_q) <= $signed(pr_q))

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the column occlusion clipper top level.
module tb_top;

  localparam int          MAX_OCC    = 32;
  localparam logic [1:0]  OP_IGNORED = 2'd3;
  localparam int          QUIET_MAX  = 6000;
  localparam int          HOLD_LEN   = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] dleft;
    logic [15:0] dright;
    logic        uncovered;
    logic        dropped;
    logic        last;
  } piece_t;

  typedef struct {
    logic [1:0]  op;
    int          xl;
    int          xr;
    int          dl;
    int          dr;
    bit          solid;
    bit          typed;
    piece_t      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow copy of the occluder table.
  int     occ_l[MAX_OCC];
  int     occ_r[MAX_OCC];
  int     occ_n = 0;

  piece_t pending_pieces[$];
  int     fails = 0;
  int     cyc = 0;
  int     quiet = 0;
  int     n_pieces_seen = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  column_occlusion_clipper_top #(.MAX_OCCLUDERS(MAX_OCC)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  function automatic bit idle_allowed();
    return !(cyc >= 3000 && cyc < 8000);
  endfunction

  // Linear depth interpolation, division truncating toward zero.
  function automatic logic [15:0] lerp_depth(int x, int xl, int xr, int dl, int dr);
    longint span;
    longint q;
    span = longint'(xr) - longint'(xl);
    if (span == 0) return dl[15:0];
    q = (longint'(dr - dl) * (longint'(x) - longint'(xl))) / span;
    return 16'(longint'(dl) + q);
  endfunction

  // Inserts an opaque piece in column order; returns 0 when the table is full.
  function automatic bit store_occluder(int l, int r);
    int pos;
    if (occ_n >= MAX_OCC) return 1'b0;
    pos = 0;
    while (pos < occ_n && occ_l[pos] <= l) pos++;
    for (int i = occ_n; i > pos; i--) begin
      occ_l[i] = occ_l[i-1];
      occ_r[i] = occ_r[i-1];
    end
    occ_l[pos] = l;
    occ_r[pos] = r;
    occ_n++;
    return 1'b1;
  endfunction

  // Works out the results of one request and updates the shadow table.
  task automatic clip_predict(input logic [1:0] op, input int xl, xr, dl, dr,
                              input bit solid, ref piece_t res[$]);
    int     cur;
    int     pl[$];
    int     pr[$];
    bit     unc;
    piece_t p;
    cur = xl;
    p = '0;
    p.last = 1'b1;
    if (op == OP_IGNORED) return;
    if (op == ccl_pkg::OP_CLEAR) begin
      occ_n = 0;
      p.kind = ccl_pkg::KIND_CLEARED;
      res.push_back(p);
      return;
    end
    if (op == ccl_pkg::OP_QUERY) begin
      unc = 1'b0;
      for (int i = 0; i < occ_n && cur <= xr; i++) begin
        if (cur < occ_l[i]) begin
          unc = 1'b1;
          break;
        end
        if (occ_r[i] + 1 > cur) cur = occ_r[i] + 1;
      end
      if (cur <= xr) unc = 1'b1;
      p.kind = ccl_pkg::KIND_ANSWER;
      p.uncovered = unc;
      res.push_back(p);
      return;
    end
    // Gather the uncovered pieces against the table as it stands.
    for (int i = 0; i < occ_n && cur <= xr; i++) begin
      if (xr < occ_l[i]) begin
        if (pl.size() < 33) begin pl.push_back(cur); pr.push_back(xr); end
        cur = xr + 1;
      end else if (cur < occ_l[i]) begin
        if (pl.size() < 33) begin pl.push_back(cur); pr.push_back(occ_l[i] - 1); end
        cur = occ_r[i] + 1;
      end else if (occ_r[i] + 1 > cur) begin
        cur = occ_r[i] + 1;
      end
    end
    if (cur <= xr && pl.size() < 33) begin
      pl.push_back(cur);
      pr.push_back(xr);
    end
    if (pl.size() == 0) begin
      p.kind = ccl_pkg::KIND_HIDDEN;
      res.push_back(p);
      return;
    end
    foreach (pl[k]) begin
      p = '0;
      p.kind   = ccl_pkg::KIND_VISIBLE;
      p.left   = pl[k][15:0];
      p.right  = pr[k][15:0];
      p.dleft  = lerp_depth(pl[k], xl, xr, dl, dr);
      p.dright = lerp_depth(pr[k], xl, xr, dl, dr);
      if (solid && !store_occluder(pl[k], pr[k])) p.dropped = 1'b1;
      p.last   = (k == pl.size() - 1);
      res.push_back(p);
    end
  endtask

  // Offers one request and books its expected results once it is taken.
  task automatic send_request(input logic [1:0] op, input int xl, xr, dl, dr,
                              input bit solid, input bit typed, input piece_t want);
    piece_t res[$];
    while (idle_allowed() && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, solid, dr[15:0], dl[15:0], xr[15:0], xl[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    clip_predict(op, $signed(xl[15:0]), $signed(xr[15:0]), dl[15:0], dr[15:0], solid, res);
    if (typed) pending_pieces.push_back(want);
    else foreach (res[i]) pending_pieces.push_back(res[i]);
  endtask

  function automatic piece_t mk(logic [1:0] kind, int l, r, dl, dr, bit unc);
    piece_t p;
    p = '0;
    p.kind = kind;
    p.left = l[15:0];
    p.right = r[15:0];
    p.dleft = dl[15:0];
    p.dright = dr[15:0];
    p.uncovered = unc;
    p.last = 1'b1;
    return p;
  endfunction

  // Result checker and activity counter.
  always @(posedge clk_i) begin
    piece_t got;
    piece_t exp_p;
    if (rst_ni) begin
      cyc++;
      quiet++;
      if (s_axis_tvalid && s_axis_tready) quiet = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        quiet = 0;
        n_pieces_seen++;
        got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
               m_axis_tdata[63:48], m_axis_tdata[64], m_axis_tdata[65], m_axis_tlast};
        if (pending_pieces.size() == 0) begin
          $error("unexpected result kind=%0d", got.kind);
          fails++;
        end else begin
          exp_p = pending_pieces.pop_front();
          if (got.kind != exp_p.kind) begin
            $error("kind: expected %0d, got %0d", exp_p.kind, got.kind); fails++;
          end
          if (got.left != exp_p.left) begin
            $error("piece_left: expected %0d, got %0d", $signed(exp_p.left),
                   $signed(got.left)); fails++;
          end
          if (got.right != exp_p.right) begin
            $error("piece_right: expected %0d, got %0d", $signed(exp_p.right),
                   $signed(got.right)); fails++;
          end
          if (got.dleft != exp_p.dleft) begin
            $error("piece_depth_left: expected %0d, got %0d", exp_p.dleft, got.dleft);
            fails++;
          end
          if (got.dright != exp_p.dright) begin
            $error("piece_depth_right: expected %0d, got %0d", exp_p.dright, got.dright);
            fails++;
          end
          if (got.uncovered != exp_p.uncovered) begin
            $error("uncovered: expected %0d, got %0d", exp_p.uncovered, got.uncovered);
            fails++;
          end
          if (got.dropped != exp_p.dropped) begin
            $error("dropped: expected %0d, got %0d", exp_p.dropped, got.dropped); fails++;
          end
          if (got.last != exp_p.last) begin
            $error("last: expected %0d, got %0d", exp_p.last, got.last); fails++;
          end
        end
      end
    end
  end

  // Output stalls: one long hold-off so the block backs up, random ones outside a window.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_pieces_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= idle_allowed() ? ($urandom_range(0, 99) >= 14) : 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  initial begin
    while (quiet < QUIET_MAX) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus: directed table, then random traffic.
  initial begin
    row_t   rows[$];
    piece_t none;
    int     r;
    int     xl;
    int     w;
    int     sent;
    none = '0;
    rows = '{
      '{ccl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, mk(ccl_pkg::KIND_CLEARED, 0, 0, 0, 0, 0)},
      '{ccl_pkg::OP_QUERY, 0, 10, 0, 0, 0, 1, mk(ccl_pkg::KIND_ANSWER, 0, 0, 0, 0, 1)},
      '{ccl_pkg::OP_CLIP, 5, 3, 9, 9, 1, 1, mk(ccl_pkg::KIND_HIDDEN, 0, 0, 0, 0, 0)},
      '{ccl_pkg::OP_QUERY, 5, 3, 0, 0, 0, 1, mk(ccl_pkg::KIND_ANSWER, 0, 0, 0, 0, 0)},
      '{ccl_pkg::OP_CLIP, -32768, 32767, 0, 65535, 0, 0, none},
      '{ccl_pkg::OP_CLIP, -32768, 32767, 65535, 0, 0, 0, none},
      '{ccl_pkg::OP_CLIP, 7, 7, 1234, 999, 1, 1,
        mk(ccl_pkg::KIND_VISIBLE, 7, 7, 1234, 1234, 0)},
      '{ccl_pkg::OP_CLIP, 0, 100, 100, 0, 1, 0, none},
      '{ccl_pkg::OP_CLIP, -50, 150, 7, 60000, 0, 0, none},
      '{ccl_pkg::OP_CLIP, 0, 100, 5, 5, 1, 1, mk(ccl_pkg::KIND_HIDDEN, 0, 0, 0, 0, 0)},
      '{ccl_pkg::OP_QUERY, 0, 100, 0, 0, 0, 1, mk(ccl_pkg::KIND_ANSWER, 0, 0, 0, 0, 0)},
      '{ccl_pkg::OP_QUERY, 50, 200, 0, 0, 0, 0, none},
      '{OP_IGNORED, 1, 2, 3, 4, 1, 0, none},
      '{ccl_pkg::OP_CLIP, 32767, 32767, 65535, 0, 1, 0, none},
      '{ccl_pkg::OP_CLIP, -32768, -32768, 0, 65535, 1, 0, none},
      '{ccl_pkg::OP_CLIP, -40, 300, 65535, 65535, 1, 0, none},
      '{ccl_pkg::OP_QUERY, -32768, 32767, 0, 0, 0, 0, none},
      '{ccl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, mk(ccl_pkg::KIND_CLEARED, 0, 0, 0, 0, 0)},
      '{ccl_pkg::OP_QUERY, -32768, 32767, 0, 0, 0, 1,
        mk(ccl_pkg::KIND_ANSWER, 0, 0, 0, 0, 1)}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      send_request(rows[i].op, rows[i].xl, rows[i].xr, rows[i].dl, rows[i].dr,
                   rows[i].solid, rows[i].typed, rows[i].want);

    sent = 0;
    while (sent < 385) begin
      r = $urandom_range(0, 999);
      if (r < 12) begin
        // Comb of single-column occluders overflowing the table, then a wide
        // clip that falls into every gap.
        send_request(ccl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, none);
        for (int k = 0; k < 34; k++)
          send_request(ccl_pkg::OP_CLIP, 2 * k, 2 * k, $urandom_range(0, 65535),
                       $urandom_range(0, 65535), 1, 0, none);
        send_request(ccl_pkg::OP_CLIP, -1, 70, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 1), 0, none);
        sent += 36;
      end else if (r < 40) begin
        send_request(ccl_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, none);
        sent++;
      end else if (r < 60) begin
        // Ignored opcode, not counted.
        send_request(OP_IGNORED, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 1), 0, none);
      end else if (r < 120) begin
        // Fully random fields.
        send_request(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 1), 0, none);
        sent++;
      end else begin
        xl = int'($urandom_range(0, 200)) - 100;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
          send_request(ccl_pkg::OP_QUERY, xl, xl + w, 0, 0, 0, 0, none);
        else
          send_request(ccl_pkg::OP_CLIP, xl, xl + w, $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 9) < 7, 0, none);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/ccl_pkg.sv
src/ccl_cell.sv
src/ccl_div.sv
src/column_occlusion_clipper_top.sv
tb/sv/tb_top.sv
